/* src/apq_pkg.sv */
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and codes for the array priority queue: request and response
// payloads, stored entry layout, status codes and controller states.
// ----------------------------------------------------------------------------
package apq_pkg;

   // request operation codes
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [15:0]        tag_in;
      logic signed [15:0] priority_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        tag_out;
      logic signed [15:0] priority_out;
   } rsp_type;

   // one stored queue entry
   typedef struct packed {
      logic [15:0]        tag;
      logic signed [15:0] prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

endpackage

/* src/array_priority_queue.sv */
// ----------------------------------------------------------------------------
// array_priority_queue
// Unsorted array priority queue with a linear scan for the highest priority.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: mode (enqueue or dequeue), tag and signed priority.
//   rsp channel: status (ok, full, empty), removed tag and priority.
//   Every request yields exactly one response, in request order.
//   Entries live in one RAM with a registered read port, oldest first.
//   Enqueue, full and empty responses are registered and appear in the cycle after the request is accepted.
//   A dequeue reads every held entry once to find the maximum (ties go to
//   the oldest), then re-reads the entries behind the winner and writes each
//   one place lower; both passes are bounded by the single RAM read port
//   and its registered read data.
//   One request is in flight at a time; req_ready is high only while idle
//   and the response register is free or being emptied.
//   A stalled receiver holds the response in its register and blocks new
//   requests. Reset empties the queue; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module array_priority_queue
   import apq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  issue_ff, issue_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [AW-1:0]  best_idx_ff, best_idx_in;
   entry_type      best_ff, best_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   entry_type         ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_raw;
   entry_type         ram_rd_data;
   logic              req_fire;

   // entry storage
   apq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = entry_type'(ram_rd_raw);
   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   // sequencer: next state, RAM access and response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[AW-1:0];
      ram_wr_data  = entry_type'({req_data.tag_in, req_data.priority_in});
      ram_rd_addr  = issue_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_in = '0;
               if (req_data.mode == MODE_ENQ) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CW'(DEPTH)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     rsp_in.status = STATUS_OK;
                     ram_wr_en     = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue reads of every held entry
            if (issue_ff != count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[AW-1:0];
               issue_in  = issue_ff + CW'(1);
            end
            // running maximum, strict compare keeps the oldest on ties
            if (rd_vld_ff) begin
               if (rd_idx_ff == '0 || ram_rd_data.prio > best_ff.prio) begin
                  best_in     = ram_rd_data;
                  best_idx_in = rd_idx_ff;
               end
            end
            if (issue_ff == count_ff && !rd_vld_ff) begin
               issue_in = CW'(best_idx_ff) + CW'(1);
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // read entry behind the winner, write it one place lower
            if (issue_ff != count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[AW-1:0];
               issue_in  = issue_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_idx_ff - AW'(1);
               ram_wr_data = ram_rd_data;
            end
            if (issue_ff == count_ff && !rd_vld_ff) begin
               count_in            = count_ff - CW'(1);
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.tag_out      = best_ff.tag;
               rsp_in.priority_out = best_ff.prio;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("request accepted while a dequeue is in progress");

   a_shift_wr_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rd_vld_ff) |-> rd_idx_ff != '0)
      else $error("shift write below index zero");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_IDLE) |-> !rsp_valid_ff)
      else $error("dequeue finished while response register occupied");

endmodule

/* src/apq_ram.sv */
// ----------------------------------------------------------------------------
// apq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module apq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/tb_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_array_priority_queue
// Self-checking testbench for the array priority queue. A behavioral model
// of the queue predicts each response as its request is accepted; a monitor
// compares every response field with the oldest prediction. Directed tests
// cover the empty and full cases, extreme fields and ties. Random traffic
// then alternates fill-heavy, drain-heavy and balanced phases. The sender
// works in bursts and the receiver changes its stall style over time.
// ----------------------------------------------------------------------------
module tb_array_priority_queue;
   import apq_pkg::*;

   localparam int Q_DEPTH      = 16;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * Q_DEPTH + 8;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // queue model state, oldest entry first
   logic [15:0]        held_tag  [Q_DEPTH];
   logic signed [15:0] held_prio [Q_DEPTH];
   int                 held_count;

   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      burst_left;
   int      n_enq_ok;
   int      n_enq_full;
   int      n_deq_ok;
   int      n_deq_empty;

   array_priority_queue #(
      .DEPTH(Q_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("array_priority_queue: mismatch");
         $finish;
      end
   end

   // apply one request to the model and return the response it must produce
   function automatic rsp_type predict_queue_op(input req_type item);
      rsp_type r;
      int      best;
      int      i;
      r        = '0;
      r.status = STATUS_OK;
      if (item.mode == MODE_ENQ) begin
         if (held_count >= Q_DEPTH) begin
            r.status = STATUS_FULL;
            n_enq_full++;
         end else begin
            held_tag[held_count]  = item.tag_in;
            held_prio[held_count] = item.priority_in;
            held_count++;
            n_enq_ok++;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
         n_deq_empty++;
      end else begin
         // strict compare keeps the oldest entry on ties
         best = 0;
         for (i = 1; i < held_count; i++) begin
            if (held_prio[i] > held_prio[best]) best = i;
         end
         r.tag_out      = held_tag[best];
         r.priority_out = held_prio[best];
         for (i = best; i < held_count - 1; i++) begin
            held_tag[i]  = held_tag[i + 1];
            held_prio[i] = held_prio[i + 1];
         end
         held_count--;
         n_deq_ok++;
      end
      return r;
   endfunction

   // drive one request, with a random gap between bursts
   task automatic send_request(input req_type item);
      int idle_len;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         idle_len  = $urandom_range(0, 6);
         repeat (idle_len) @(negedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
         else burst_left = $urandom_range(1, 6);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_queue_op(item));
      burst_left--;
   endtask

   task automatic send_enqueue(input logic [15:0] tag, input logic [15:0] prio);
      req_type item;
      item.mode        = MODE_ENQ;
      item.tag_in      = tag;
      item.priority_in = prio;
      send_request(item);
   endtask

   // dequeue carries random don't-care fields
   task automatic send_dequeue();
      req_type item;
      item.mode        = MODE_DEQ;
      item.tag_in      = 16'($urandom);
      item.priority_in = 16'($urandom);
      send_request(item);
   endtask

   // receiver: switches among four stall styles at random
   int rx_style = 0;
   int rx_left  = 0;
   int rx_tick  = 0;
   always @(negedge clock) begin
      if (rx_left <= 0) begin
         rx_style = $urandom_range(0, 3);
         rx_left  = $urandom_range(20, 100);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (rx_tick % 4 == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d tag %h priority %0d",
                   rsp_data.status, rsp_data.tag_out, rsp_data.priority_out);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.tag_out !== exp_rsp.tag_out) begin
               $error("tag_out: expected %h, actual %h", exp_rsp.tag_out, rsp_data.tag_out);
               error_count++;
            end
            if (rsp_data.priority_out !== exp_rsp.priority_out) begin
               $error("priority_out: expected %0d, actual %0d",
                      exp_rsp.priority_out, rsp_data.priority_out);
               error_count++;
            end
         end
      end
   end

   // dequeue from an empty queue
   task automatic test_empty_queue();
      send_dequeue();
      send_dequeue();
   endtask

   // fill with extreme tags and priorities, then hit the full case
   task automatic test_fill_to_full();
      logic [15:0] fill_tags [16] = '{
         16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h7FFF, 16'h1234,
         16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'hBEEF, 16'h0002};
      logic [15:0] fill_prios [16] = '{
         16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h0005,
         16'h0005, 16'hFFFE, 16'h7FFE, 16'h0000, 16'h0003, 16'h8001, 16'h7FFF, 16'h0064};
      for (int i = 0; i < 16; i++) send_enqueue(fill_tags[i], fill_prios[i]);
      send_enqueue(16'hFFFF, 16'h7FFF);
   endtask

   // maximum priority three times over: oldest of the ties goes first
   task automatic test_tie_order();
      repeat (5) send_dequeue();
   endtask

   // phases biased toward filling, draining or balance
   task automatic test_random_traffic();
      int sent;
      int phase_len;
      int enq_pct;
      int prio_class;
      logic [15:0] prio;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(30, 70);
         case ($urandom_range(0, 2))
            0: enq_pct = 80;
            1: enq_pct = 25;
            default: enq_pct = 55;
         endcase
         prio_class = $urandom_range(0, 2);
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= enq_pct) begin
               case (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : prio_class)
                  0: prio = 16'($signed($urandom_range(0, 6)) - 3);
                  1: prio = 16'($urandom);
                  default: prio = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               endcase
               send_enqueue(16'($urandom), prio);
            end else begin
               send_dequeue();
            end
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      held_count  = 0;
      burst_left  = 0;
      n_enq_ok    = 0;
      n_enq_full  = 0;
      n_deq_ok    = 0;
      n_deq_empty = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_fill_to_full();
      test_tie_order();
      test_random_traffic();

      // let every response drain
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d enqueues accepted, %0d refused as full", n_enq_ok, n_enq_full);
      $display("covered %0d dequeues served, %0d on an empty queue", n_deq_ok, n_deq_empty);
      if (error_count == 0) begin
         $display("array_priority_queue: match");
      end else begin
         $display("array_priority_queue: mismatch");
      end
      $finish;
   end

endmodule
